// File: design/mst_pkg.sv
// shared types and constants of the markup stream tokenizer
`timescale 1ns / 1ps
`default_nettype none

package mst_pkg;

   localparam int OFFSET_BITS_DEFAULT = 32;
   localparam int OUT_W = 32;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_LT = 8'h3C;
   localparam logic [7:0] CHAR_GT = 8'h3E;
   localparam logic [7:0] CHAR_DASH = 8'h2D;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   typedef enum logic [1:0] {
      KIND_TEXT  = 2'd0,
      KIND_BEGIN = 2'd1,
      KIND_END   = 2'd2,
      KIND_EOD   = 2'd3
   } kind_type;

   typedef enum logic [6:0] {
      MODE_DATA  = 7'b0000001,
      MODE_TAG   = 7'b0000010,
      MODE_PSCOM = 7'b0000100,
      MODE_COM   = 7'b0001000,
      MODE_PECOM = 7'b0010000,
      MODE_SQ    = 7'b0100000,
      MODE_DQ    = 7'b1000000
   } mode_type;

   // all results caused by one byte, in output order text, tag, end of document
   typedef struct packed {
      logic             text_v;
      logic [OUT_W-1:0] text_start;
      logic [OUT_W-1:0] text_len;
      logic             tag_v;
      kind_type         tag_kind;
      logic [OUT_W-1:0] tag_start;
      logic [OUT_W-1:0] tag_len;
      logic             eod_v;
      logic [OUT_W-1:0] eod_start;
   } record_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// File: design/mst_if.sv
// valid/ready channel interfaces for byte input and token output
`timescale 1ns / 1ps
`default_nettype none

interface mst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_document;

   modport source (output valid, output data_byte, output end_of_document, input ready);
   modport sink (input valid, input data_byte, input end_of_document, output ready);
endinterface

interface mst_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  element_kind;
   logic [31:0] start_offset;
   logic [31:0] element_length;
   logic        last_of_run;

   modport source (output valid, output element_kind, output start_offset,
                   output element_length, output last_of_run, input ready);
   modport sink (input valid, input element_kind, input start_offset,
                 input element_length, input last_of_run, output ready);
endinterface

`default_nettype wire

// File: design/mst_front.sv
// byte scanner: mode tracking and building of a result record for each byte that causes results
`timescale 1ns / 1ps
`default_nettype none

module mst_front
   import mst_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   mst_req_if.sink               req,
   input  wire queue_status_type status,
   output logic                  push_valid,
   output record_type            push_record
);

   localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

   mode_type               mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] seg_ff, seg_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic                   sn_ff, sn_in;
   logic                   ct_ff, ct_in;

   logic                   accept;
   logic [7:0]             c;
   logic                   eod;
   logic [OFFSET_BITS-1:0] next;
   logic                   is_space;
   logic                   close;
   logic                   open_tag;
   logic                   tag_side;
   mode_type               mode_upd;
   logic                   sn_upd;
   logic                   ct_upd;
   logic                   ct_eff;
   logic [OFFSET_BITS-1:0] seg_eff;
   logic [OFFSET_BITS-1:0] text_end;
   logic                   text_v;
   logic                   tag_v;

   function automatic logic [OUT_W-1:0] to_out(input logic [OFFSET_BITS-1:0] v);
      logic [OFFSET_BITS+OUT_W-1:0] w;
      w = {{OUT_W{1'b0}}, v};
      return w[OUT_W-1:0];
   endfunction

   assign req.ready = !status.full;
   assign accept = req.valid && req.ready;
   assign c = req.data_byte;
   assign eod = req.end_of_document;

   assign next = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
   assign is_space = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));

   always_comb begin
      mode_upd = mode_ff;
      close = 1'b0;
      open_tag = 1'b0;
      tag_side = 1'b1;
      unique case (mode_ff)
         MODE_TAG: begin
            if (c == CHAR_GT) close = 1'b1;
            else if (c == CHAR_DASH) mode_upd = MODE_PSCOM;
            else if (c == CHAR_DQUOTE) mode_upd = MODE_DQ;
            else if (c == CHAR_SQUOTE) mode_upd = MODE_SQ;
         end
         MODE_PSCOM: begin
            if (c == CHAR_GT) close = 1'b1;
            else mode_upd = (c == CHAR_DASH) ? MODE_COM : MODE_TAG;
         end
         MODE_SQ: begin
            if (c == CHAR_GT) close = 1'b1;
            else if (c == CHAR_SQUOTE) mode_upd = MODE_TAG;
         end
         MODE_DQ: begin
            if (c == CHAR_GT) close = 1'b1;
            else if (c == CHAR_DQUOTE) mode_upd = MODE_TAG;
         end
         MODE_COM: begin
            if (c == CHAR_DASH) mode_upd = MODE_PECOM;
         end
         MODE_PECOM: begin
            if (c == CHAR_GT) close = 1'b1;
            else mode_upd = (c == CHAR_DASH) ? MODE_TAG : MODE_COM;
         end
         default: begin
            // data mode, and any code that cannot be reached
            tag_side = 1'b0;
            open_tag = (c == CHAR_LT);
         end
      endcase
   end

   // end tag detection: first non-space byte of the tag
   always_comb begin
      sn_upd = sn_ff;
      ct_upd = ct_ff;
      if (tag_side && !close && !sn_ff && !is_space) begin
         sn_upd = 1'b1;
         ct_upd = (c == CHAR_SLASH);
      end
   end

   assign ct_eff = open_tag ? 1'b0 : ct_upd;
   assign seg_eff = open_tag ? pos_ff : seg_ff;
   assign text_end = open_tag ? pos_ff : next;
   assign text_v = !tag_side && (open_tag || eod) && (text_end > seg_ff);
   assign tag_v = close || (eod && (tag_side || open_tag));

   always_comb begin
      push_record.text_v = text_v;
      push_record.text_start = to_out(seg_ff);
      push_record.text_len = to_out(text_end - seg_ff);
      push_record.tag_v = tag_v;
      push_record.tag_kind = ct_eff ? KIND_END : KIND_BEGIN;
      push_record.tag_start = to_out(seg_eff);
      push_record.tag_len = to_out((next > seg_eff) ? next - seg_eff : '0);
      push_record.eod_v = eod;
      push_record.eod_start = to_out(next);
   end

   assign push_valid = accept && (text_v || tag_v || eod);

   always_comb begin
      mode_in = mode_ff;
      seg_in = seg_ff;
      pos_in = pos_ff;
      sn_in = sn_ff;
      ct_in = ct_ff;
      if (accept) begin
         if (eod) begin
            mode_in = MODE_DATA;
            seg_in = '0;
            pos_in = '0;
            sn_in = 1'b0;
            ct_in = 1'b0;
         end else if (open_tag) begin
            mode_in = MODE_TAG;
            seg_in = pos_ff;
            pos_in = next;
            sn_in = 1'b0;
            ct_in = 1'b0;
         end else if (close) begin
            mode_in = MODE_DATA;
            seg_in = next;
            pos_in = next;
            sn_in = 1'b0;
            ct_in = 1'b0;
         end else begin
            mode_in = mode_upd;
            pos_in = next;
            sn_in = sn_upd;
            ct_in = ct_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_DATA;
         seg_ff <= '0;
         pos_ff <= '0;
         sn_ff <= 1'b0;
         ct_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         seg_ff <= seg_in;
         pos_ff <= pos_in;
         sn_ff <= sn_in;
         ct_ff <= ct_in;
      end
   end

   // a finished document leaves the scanner as after reset
   a_eod_restart: assert property (@(posedge clock) disable iff (reset)
      accept && eod |=> (mode_ff == MODE_DATA) && (pos_ff == '0) && (seg_ff == '0))
      else $error("scanner state not cleared after end of document");

   a_seg_behind_pos: assert property (@(posedge clock) disable iff (reset)
      seg_ff <= pos_ff)
      else $error("segment start ahead of byte position");

   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      accept && !eod |=> (pos_ff == $past(pos_ff) + 1'b1) || (pos_ff == POS_MAX))
      else $error("byte position did not advance by one");

endmodule

`default_nettype wire

// File: design/mst_queue.sv
// short record queue between the scanner and the result serializer
`timescale 1ns / 1ps
`default_nettype none

module mst_queue
   import mst_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push_valid,
   input  wire record_type  push_record,
   input  wire logic        pop,
   output record_type       head,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W:0] FULL_COUNT = (PTR_W + 1)'(QUEUE_DEPTH);

   record_type         entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;

   assign status.full = (count_ff == FULL_COUNT);
   assign status.empty = (count_ff == '0);
   assign head = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + {{PTR_W{1'b0}}, push_valid} - {{PTR_W{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_record;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: design/mst_back.sv
// result serializer: sends the results of each record one transaction at a time
`timescale 1ns / 1ps
`default_nettype none

module mst_back
   import mst_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire record_type       head,
   input  wire queue_status_type status,
   output logic                  pop,
   mst_rsp_if.source             rsp
);

   logic [2:0]       sent_ff, sent_in;
   logic             out_valid_ff, out_valid_in;
   kind_type         kind_ff, kind_in;
   logic [OUT_W-1:0] start_ff, start_in;
   logic [OUT_W-1:0] len_ff, len_in;
   logic             last_ff, last_in;

   logic [2:0]       remaining;
   logic [2:0]       lowest;
   logic             last;
   logic             load;

   // slot bits: text, tag, end of document
   assign remaining = {head.eod_v, head.tag_v, head.text_v} & ~sent_ff;
   assign lowest = remaining & (~remaining + 3'd1);
   assign last = ((remaining & ~lowest) == 3'b000);
   assign load = !status.empty && (!out_valid_ff || rsp.ready);
   assign pop = load && last;

   always_comb begin
      kind_in = kind_ff;
      start_in = start_ff;
      len_in = len_ff;
      last_in = last_ff;
      sent_in = sent_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      if (load) begin
         out_valid_in = 1'b1;
         last_in = last;
         sent_in = last ? 3'b000 : (sent_ff | lowest);
         if (lowest[0]) begin
            kind_in = KIND_TEXT;
            start_in = head.text_start;
            len_in = head.text_len;
         end else if (lowest[1]) begin
            kind_in = head.tag_kind;
            start_in = head.tag_start;
            len_in = head.tag_len;
         end else begin
            kind_in = KIND_EOD;
            start_in = head.eod_start;
            len_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff <= 3'b000;
         out_valid_ff <= 1'b0;
      end else begin
         sent_ff <= sent_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      start_ff <= start_in;
      len_ff <= len_in;
      last_ff <= last_in;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.element_kind = kind_ff;
   assign rsp.start_offset = start_ff;
   assign rsp.element_length = len_ff;
   assign rsp.last_of_run = last_ff;

   a_sent_cleared: assert property (@(posedge clock) disable iff (reset)
      pop |=> sent_ff == 3'b000)
      else $error("slot mask not cleared after record retired");

   a_partial_keeps_head: assert property (@(posedge clock) disable iff (reset)
      load && !last |=> !status.empty)
      else $error("record left the queue before all its results were sent");

endmodule

`default_nettype wire

// File: design/markup_stream_tokenizer_core.sv
// top level of the markup stream tokenizer
`timescale 1ns / 1ps
`default_nettype none

// Splits a markup byte stream into text runs, begin tags, end tags and an
// end of document marker. One byte is accepted per cycle: the scanner only
// updates its mode and position registers per byte. Every result that a byte
// causes (at most three) is sent as its own rsp transaction, from a
// four-record queue; a byte is held off only while that queue is full, which
// happens when the rsp side stalls or falls behind on bytes that cause
// several results. Each result is written to the queue and then to the
// registered rsp outputs. Offsets and lengths saturate at the largest
// OFFSET_BITS value and are reported as their low 32 bits. After the end of
// document byte the block starts a new document at offset zero.
module markup_stream_tokenizer_core
   import mst_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   mst_req_if.sink   req,
   mst_rsp_if.source rsp
);

   logic             push_valid;
   record_type       push_record;
   record_type       head;
   queue_status_type status;
   logic             pop;

   mst_front #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .status     (status),
      .push_valid (push_valid),
      .push_record(push_record)
   );

   mst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_record(push_record),
      .pop        (pop),
      .head       (head),
      .status     (status)
   );

   mst_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .status(status),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule

`default_nettype wire

// File: tb/sv/markup_stream_tokenizer_core_checker.sv
// checker: predicts the tokens of the markup stream tokenizer and compares each rsp transaction
`timescale 1ns / 1ps

module markup_stream_tokenizer_core_checker
   import mst_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   mst_req_if       req,
   mst_rsp_if       rsp,
   output int       fail_count,
   output int       pending
);

   localparam logic [31:0] POS_MAX = '1;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] start;
      logic [31:0] len;
      logic        last;
   } token_type;

   token_type   expected_tokens[$];
   mode_type    scan_mode;
   logic [31:0] seg_start;
   logic [31:0] byte_pos;
   logic        seen_nonspace;
   logic        closing_tag;
   int          errors = 0;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == POS_MAX) ? POS_MAX : v + 32'd1;
   endfunction

   function automatic logic [31:0] sat_len(input logic [31:0] from, input logic [31:0] upto);
      return (upto > from) ? upto - from : 32'd0;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic token_type make_token(input kind_type k, input logic [31:0] s,
                                            input logic [31:0] l);
      token_type t;
      t.kind = k;
      t.start = s;
      t.len = l;
      t.last = 1'b0;
      return t;
   endfunction

   function automatic kind_type open_tag_kind();
      return closing_tag ? KIND_END : KIND_BEGIN;
   endfunction

   task automatic clear_scan();
      scan_mode = MODE_DATA;
      seg_start = '0;
      byte_pos = '0;
      seen_nonspace = 1'b0;
      closing_tag = 1'b0;
   endtask

   task automatic scan_byte(input logic [7:0] c, input logic eod);
      token_type   found[$];
      logic [31:0] pos;
      logic [31:0] nxt;
      logic        close_now;
      pos = byte_pos;
      nxt = sat_inc(pos);
      close_now = 1'b0;
      if (scan_mode == MODE_DATA && c == CHAR_LT) begin
         if (pos > seg_start) found.push_back(make_token(KIND_TEXT, seg_start,
                                                         sat_len(seg_start, pos)));
         seg_start = pos;
         scan_mode = MODE_TAG;
         seen_nonspace = 1'b0;
         closing_tag = 1'b0;
         if (eod) begin
            // the lone '<' is flushed as a tag of its own
            found.push_back(make_token(open_tag_kind(), seg_start, sat_len(seg_start, nxt)));
            found.push_back(make_token(KIND_EOD, nxt, 32'd0));
            clear_scan();
         end else begin
            byte_pos = nxt;
         end
      end else begin
         case (scan_mode)
            MODE_TAG: begin
               if (c == CHAR_GT) close_now = 1'b1;
               else if (c == CHAR_DASH) scan_mode = MODE_PSCOM;
               else if (c == CHAR_DQUOTE) scan_mode = MODE_DQ;
               else if (c == CHAR_SQUOTE) scan_mode = MODE_SQ;
            end
            MODE_PSCOM: begin
               if (c == CHAR_GT) close_now = 1'b1;
               else scan_mode = (c == CHAR_DASH) ? MODE_COM : MODE_TAG;
            end
            MODE_SQ: begin
               if (c == CHAR_GT) close_now = 1'b1;
               else if (c == CHAR_SQUOTE) scan_mode = MODE_TAG;
            end
            MODE_DQ: begin
               if (c == CHAR_GT) close_now = 1'b1;
               else if (c == CHAR_DQUOTE) scan_mode = MODE_TAG;
            end
            MODE_COM: begin
               if (c == CHAR_DASH) scan_mode = MODE_PECOM;
            end
            MODE_PECOM: begin
               if (c == CHAR_GT) close_now = 1'b1;
               else scan_mode = (c == CHAR_DASH) ? MODE_TAG : MODE_COM;
            end
            default: ;
         endcase
         // end tag detection looks at the first non-space byte inside the tag
         if (scan_mode != MODE_DATA && !close_now && !seen_nonspace && !is_space(c)) begin
            seen_nonspace = 1'b1;
            closing_tag = (c == CHAR_SLASH);
         end
         if (close_now) begin
            found.push_back(make_token(open_tag_kind(), seg_start, sat_len(seg_start, nxt)));
            seg_start = nxt;
            scan_mode = MODE_DATA;
            seen_nonspace = 1'b0;
            closing_tag = 1'b0;
         end
         if (eod) begin
            if (scan_mode == MODE_DATA) begin
               if (nxt > seg_start) found.push_back(make_token(KIND_TEXT, seg_start,
                                                               sat_len(seg_start, nxt)));
            end else begin
               found.push_back(make_token(open_tag_kind(), seg_start,
                                          sat_len(seg_start, nxt)));
            end
            found.push_back(make_token(KIND_EOD, nxt, 32'd0));
            clear_scan();
         end else begin
            byte_pos = nxt;
         end
      end
      if (found.size() > 0) found[found.size()-1].last = 1'b1;
      foreach (found[i]) expected_tokens.push_back(found[i]);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      token_type want;
      if (reset) begin
         clear_scan();
         expected_tokens.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_tokens.size() == 0) begin
               $error("unexpected transaction: kind %0d start %0d length %0d",
                      rsp.element_kind, rsp.start_offset, rsp.element_length);
               errors++;
            end else begin
               want = expected_tokens.pop_front();
               check_field("element_kind", 32'(want.kind), 32'(rsp.element_kind));
               check_field("start_offset", want.start, rsp.start_offset);
               check_field("element_length", want.len, rsp.element_length);
               check_field("last_of_run", 32'(want.last), 32'(rsp.last_of_run));
            end
         end
         if (req.valid && req.ready) scan_byte(req.data_byte, req.end_of_document);
      end
      fail_count <= errors;
      pending <= expected_tokens.size();
   end

endmodule

// File: tb/sv/markup_stream_tokenizer_core_tb.sv
// testbench top: byte stimulus, receiver stalls and verdict for the markup stream tokenizer
`timescale 1ns / 1ps

module markup_stream_tokenizer_core_tb;
   import mst_pkg::*;

   localparam int HOLD_CYCLES = 250;
   localparam int PHASE_BYTES = 105;
   localparam logic [7:0] CHAR_BANG = 8'h21;
   localparam logic [7:0] CHAR_EQ = 8'h3D;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   send_idle;
   int   recv_idle;
   logic hold_off;
   logic [7:0] doc_bytes[$];

   mst_req_if req_if ();
   mst_rsp_if rsp_if ();

   markup_stream_tokenizer_core u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   markup_stream_tokenizer_core_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .rsp        (rsp_if),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Verification failed");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off = 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle);
            @(negedge clock);
         end
      end
   end

   task automatic send_byte(input logic [7:0] value, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data_byte <= value;
      req_if.end_of_document <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic send_document();
      foreach (doc_bytes[i]) send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
      doc_bytes.delete();
   endtask

   task automatic append_text(input string s);
      for (int i = 0; i < s.len(); i++) doc_bytes.push_back(s[i]);
   endtask

   function automatic logic [7:0] text_char();
      logic [7:0] c;
      c = 8'($urandom_range(8'h20, 8'h7E));
      return (c == CHAR_LT) ? 8'h78 : c;
   endfunction

   function automatic logic [7:0] space_char();
      int r;
      r = $urandom_range(0, 5);
      return (r == 5) ? CHAR_SPACE : CHAR_TAB + r[7:0];
   endfunction

   task automatic add_name();
      repeat ($urandom_range(1, 4)) doc_bytes.push_back(8'h61 + 8'($urandom_range(0, 25)));
   endtask

   // mostly well-formed markup with random content, some noise and broken tags
   task automatic build_random_document();
      int k;
      int q;
      logic [7:0] quote;
      logic [7:0] c;
      repeat ($urandom_range(1, 5)) begin
         k = $urandom_range(99);
         if (k < 30) begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(5) == 0) doc_bytes.push_back(space_char());
               else doc_bytes.push_back(text_char());
            end
         end else if (k < 60) begin
            doc_bytes.push_back(CHAR_LT);
            repeat ($urandom_range(0, 2)) doc_bytes.push_back(space_char());
            if ($urandom_range(1)) doc_bytes.push_back(CHAR_SLASH);
            add_name();
            repeat ($urandom_range(0, 2)) begin
               doc_bytes.push_back(space_char());
               add_name();
               doc_bytes.push_back(CHAR_EQ);
               q = $urandom_range(2);
               if (q == 0) begin
                  repeat ($urandom_range(1, 3)) doc_bytes.push_back(text_char());
               end else begin
                  quote = (q == 1) ? CHAR_SQUOTE : CHAR_DQUOTE;
                  doc_bytes.push_back(quote);
                  repeat ($urandom_range(0, 4)) begin
                     c = text_char();
                     doc_bytes.push_back((c == quote) ? 8'h2E : c);
                  end
                  doc_bytes.push_back(quote);
               end
            end
            doc_bytes.push_back(CHAR_GT);
         end else if (k < 75) begin
            append_text("<!--");
            repeat ($urandom_range(0, 6)) doc_bytes.push_back(text_char());
            if ($urandom_range(9) == 0) append_text("->");
            else append_text("-->");
         end else if (k < 88) begin
            doc_bytes.push_back(8'($urandom_range(255)));
         end else begin
            doc_bytes.push_back(CHAR_LT);
            repeat ($urandom_range(0, 4)) doc_bytes.push_back(8'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      int phase_bytes;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data_byte = '0;
      req_if.end_of_document = 1'b0;
      rsp_if.ready = 1'b0;
      hold_off = 1'b0;
      send_idle = 7;
      recv_idle = 85;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extreme bytes, dash close from the tag start, stray '<', end tag after a space
      doc_bytes.push_back(8'h00);
      append_text("<a-><!--");
      doc_bytes.push_back(8'hFF);
      append_text("-><");
      doc_bytes.push_back(CHAR_CR);
      append_text("/<>z");
      send_document();
      // document ending on its opening '<'
      append_text("<");
      send_document();
      // quote closed by '>', then unterminated end tag
      append_text("<'>< /");
      send_document();
      // unterminated comment hides the '>'
      append_text("<!-->");
      send_document();
      // double quote closed by '>' as the last byte, no trailing text
      append_text("<\"-->");
      send_document();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 7 : (phase == 1) ? 85 : 0;
         recv_idle = (phase == 0) ? 85 : (phase == 1) ? 7 : 0;
         if (phase == 2) hold_off = 1'b1;
         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            build_random_document();
            phase_bytes += doc_bytes.size();
            send_document();
         end
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
